FILE: src/lpm2p_pkg.sv
// ----------------------------------------------------------------------------
// lpm2p_pkg
// Shared constants, register map and arctangent table for the line
// parameter conversion pipeline.
// ----------------------------------------------------------------------------
package lpm2p_pkg;

    localparam int CORDIC_STAGES_DEF = 18;
    localparam int ATAN_ENTRIES      = 24;

    // Q.30 angles
    localparam logic [32:0] PI_Q30      = 33'd3373259426;
    localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
    localparam logic [29:0] GAIN_Q30    = 30'd652032874;

    localparam logic [4:0]  D_MIN_Q24     = 5'd17;
    localparam logic [18:0] THETA_LIMIT   = 19'd205887;
    localparam logic [26:0] RHO_POS_LIMIT = 27'd67108863;
    localparam logic [27:0] RHO_NEG_LIMIT = 28'd67108864;

    localparam logic [21:0] FOCAL_X_RST  = 22'd256000;
    localparam logic [21:0] FOCAL_Y_RST  = 22'd256000;
    localparam logic [20:0] CENTER_U_RST = 21'd81920;
    localparam logic [20:0] CENTER_V_RST = 21'd61440;

    localparam int APB_AW = 4;

    typedef enum logic [1:0] {
        REG_FOCAL_X  = 2'd0,
        REG_FOCAL_Y  = 2'd1,
        REG_CENTER_U = 2'd2,
        REG_CENTER_V = 2'd3
    } t_reg_idx;

    // arctan(2^-i) in Q.30
    function automatic logic [29:0] atan_q30(input int i);
        logic [29:0] v;
        unique case (i)
            0:  v = 30'd843314857;
            1:  v = 30'd497837830;
            2:  v = 30'd263043837;
            3:  v = 30'd133525159;
            4:  v = 30'd67021687;
            5:  v = 30'd33543516;
            6:  v = 30'd16775851;
            7:  v = 30'd8388437;
            8:  v = 30'd4194283;
            9:  v = 30'd2097149;
            10: v = 30'd1048576;
            11: v = 30'd524288;
            12: v = 30'd262144;
            13: v = 30'd131072;
            14: v = 30'd65536;
            15: v = 30'd32768;
            16: v = 30'd16384;
            17: v = 30'd8192;
            18: v = 30'd4096;
            19: v = 30'd2048;
            20: v = 30'd1024;
            21: v = 30'd512;
            22: v = 30'd256;
            23: v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/line_param_meter_to_pixel.sv
// ----------------------------------------------------------------------------
// line_param_meter_to_pixel
// Converts a line from normalized polar form to pixel polar form using the
// pinhole intrinsics held in four APB registers.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one line per transfer (rho_norm, theta_norm); the
//   master stream returns rho_pix and theta_pix in tdata and the degenerate
//   flag in tuser. Intrinsics are written over APB while the stream is idle.
//   The datapath is a fully pipelined chain: rotation CORDIC for sin/cos,
//   intrinsic multipliers, vectoring CORDIC for atan2 and length, gain
//   multiplier and a 35-stage restoring divider, one register stage each.
//   Throughput is one transfer per cycle while the output register is empty or being taken.
//   All stages advance together whenever the output register is empty or
//   being taken; while a result waits untaken, every stage and s_axis_tready
//   hold, so bubbles stay where they are. s_axis_tready follows
//   m_axis_tready combinationally when the output register is full.
//   Reset clears every valid bit and loads the register reset values;
//   the first transfer may be accepted in the cycle after reset is released.
// ----------------------------------------------------------------------------
module line_param_meter_to_pixel
    import lpm2p_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // slave stream: [19:0] rho_norm, [38:20] theta_norm, [39] zero
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,
    // master stream: [26:0] rho_pix, [45:27] theta_pix, [47:46] zero
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata,
    // [0] degenerate
    output logic              m_axis_tuser,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int NS  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int RW  = 34;  // rotation x/y
    localparam int RZW = 33;  // rotation angle
    localparam int VW  = 43;  // vectoring x/y
    localparam int VZW = 35;  // vectoring angle
    localparam int NW  = 60;  // numerator
    localparam int DW  = 42;  // length
    localparam int QB  = 35;  // quotient bits, 9 fraction bits

    // ---------------- configuration ----------------
    logic [21:0] r_focal_x, r_focal_y;
    logic [20:0] r_center_u, r_center_v;
    logic [35:0] r_fxy;
    logic [43:0] fxy_full;
    t_reg_idx    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= FOCAL_X_RST;
            r_focal_y  <= FOCAL_Y_RST;
            r_center_u <= CENTER_U_RST;
            r_center_v <= CENTER_V_RST;
        end else if (psel && penable && pwrite) begin
            unique case (cfg_idx)
                REG_FOCAL_X:  r_focal_x  <= pwdata[21:0];
                REG_FOCAL_Y:  r_focal_y  <= pwdata[21:0];
                REG_CENTER_U: r_center_u <= pwdata[20:0];
                REG_CENTER_V: r_center_v <= pwdata[20:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FOCAL_X:  prdata = {10'd0, r_focal_x};
            REG_FOCAL_Y:  prdata = {10'd0, r_focal_y};
            REG_CENTER_U: prdata = {11'd0, r_center_u};
            REG_CENTER_V: prdata = {11'd0, r_center_v};
        endcase
    end

    assign fxy_full = r_focal_x * r_focal_y;
    always_ff @(posedge i_clk) begin
        r_fxy <= fxy_full[43:8];
    end

    // ---------------- pipeline control ----------------
    logic r_out_vld;
    logic en;

    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_out_vld;

    // ---------------- input stage: angle reduction ----------------
    logic signed [RW-1:0]  r_rx   [NS+1];
    logic signed [RW-1:0]  r_ry   [NS+1];
    logic signed [RZW-1:0] r_rz   [NS+1];
    logic                  r_flip [NS+1];
    logic signed [19:0]    r_rho  [NS+1];
    logic                  r_rvld [NS+1];

    logic signed [RZW-1:0] z_in, z_red;
    logic                  flip_in;

    always_comb begin
        z_in    = $signed({s_axis_tdata[38:20], 14'd0});
        z_red   = z_in;
        flip_in = 1'b0;
        priority if (z_in > $signed(HALF_PI_Q30)) begin
            z_red   = z_in - $signed(PI_Q30);
            flip_in = 1'b1;
        end else if (z_in < -$signed(HALF_PI_Q30)) begin
            z_red   = z_in + $signed(PI_Q30);
            flip_in = 1'b1;
        end else begin
            z_red   = z_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvld[0] <= 1'b0;
        end else if (en) begin
            r_rvld[0] <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx[0]   <= RW'($signed({1'b0, GAIN_Q30}));
            r_ry[0]   <= '0;
            r_rz[0]   <= z_red;
            r_flip[0] <= flip_in;
            r_rho[0]  <= $signed(s_axis_tdata[19:0]);
        end
    end

    // ---------------- rotation CORDIC ----------------
    for (genvar i = 0; i < NS; i++) begin : g_rot
        logic signed [RZW-1:0] at;
        assign at = $signed({3'b000, atan_q30(i)});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rvld[i+1] <= 1'b0;
            end else if (en) begin
                r_rvld[i+1] <= r_rvld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_rz[i][RZW-1]) begin
                    r_rx[i+1] <= r_rx[i] - (r_ry[i] >>> i);
                    r_ry[i+1] <= r_ry[i] + (r_rx[i] >>> i);
                    r_rz[i+1] <= r_rz[i] - at;
                end else begin
                    r_rx[i+1] <= r_rx[i] + (r_ry[i] >>> i);
                    r_ry[i+1] <= r_ry[i] - (r_rx[i] >>> i);
                    r_rz[i+1] <= r_rz[i] + at;
                end
                r_flip[i+1] <= r_flip[i];
                r_rho[i+1]  <= r_rho[i];
            end
        end
    end

    // ---------------- intrinsic scaling: A = fy*c, B = fx*s ----------------
    logic signed [RW-1:0] cos_v, sin_v;
    logic signed [56:0]   pa_full, pb_full, n1_full;
    logic signed [VW-1:0] r_a, r_b;
    logic signed [56:0]   r_n1;
    logic                 r_ab_vld;

    assign cos_v   = r_flip[NS] ? -r_rx[NS] : r_rx[NS];
    assign sin_v   = r_flip[NS] ? -r_ry[NS] : r_ry[NS];
    assign pa_full = $signed({1'b0, r_focal_y}) * cos_v;
    assign pb_full = $signed({1'b0, r_focal_x}) * sin_v;
    assign n1_full = $signed({1'b0, r_fxy}) * r_rho[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ab_vld <= 1'b0;
        end else if (en) begin
            r_ab_vld <= r_rvld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a  <= pa_full[56:14];
            r_b  <= pb_full[56:14];
            r_n1 <= n1_full;
        end
    end

    // ---------------- vectoring set-up and centre products ----------------
    logic signed [VW-1:0]  r_vx  [NS+1];
    logic signed [VW-1:0]  r_vy  [NS+1];
    logic signed [VZW-1:0] r_vz  [NS+1];
    logic signed [NW-1:0]  r_n   [NS+1];
    logic                  r_vvld[NS+1];
    logic signed [64:0]    r_pu, r_pv;
    logic signed [56:0]    r_n1b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vvld[0] <= 1'b0;
        end else if (en) begin
            r_vvld[0] <= r_ab_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // mirror into the right half plane, start the angle at +-pi
            if (r_a[VW-1]) begin
                r_vx[0] <= -r_a;
                r_vy[0] <= -r_b;
                r_vz[0] <= r_b[VW-1] ? -$signed({2'b00, PI_Q30}) : $signed({2'b00, PI_Q30});
            end else begin
                r_vx[0] <= r_a;
                r_vy[0] <= r_b;
                r_vz[0] <= '0;
            end
            r_pu  <= $signed({1'b0, r_center_u}) * r_a;
            r_pv  <= $signed({1'b0, r_center_v}) * r_b;
            r_n1b <= r_n1;
            r_n[0] <= '0;
        end
    end

    // ---------------- vectoring CORDIC ----------------
    logic signed [65:0] puv_sum;
    assign puv_sum = {r_pu[64], r_pu} + {r_pv[64], r_pv};

    for (genvar i = 0; i < NS; i++) begin : g_vec
        logic signed [VZW-1:0] at;
        assign at = $signed({5'b00000, atan_q30(i)});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vvld[i+1] <= 1'b0;
            end else if (en) begin
                r_vvld[i+1] <= r_vvld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_vy[i][VW-1]) begin
                    r_vx[i+1] <= r_vx[i] + (r_vy[i] >>> i);
                    r_vy[i+1] <= r_vy[i] - (r_vx[i] >>> i);
                    r_vz[i+1] <= r_vz[i] + at;
                end else begin
                    r_vx[i+1] <= r_vx[i] - (r_vy[i] >>> i);
                    r_vy[i+1] <= r_vy[i] + (r_vx[i] >>> i);
                    r_vz[i+1] <= r_vz[i] - at;
                end
            end
        end

        if (i == 0) begin : g_nsum
            logic signed [65:0] sh;
            assign sh = puv_sum >>> 8;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_n[1] <= NW'(r_n1b) + sh[NW-1:0];
                end
            end
        end else begin : g_ncarry
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_n[i+1] <= r_n[i];
                end
            end
        end
    end

    // ---------------- gain correction ----------------
    logic [63:0]           dp_full;
    logic [DW-1:0]         r_d;
    logic signed [VZW-1:0] r_dz;
    logic signed [NW-1:0]  r_dn;
    logic                  r_dvld;

    assign dp_full = r_vx[NS][VW-2:8] * GAIN_Q30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld <= 1'b0;
        end else if (en) begin
            r_dvld <= r_vvld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d  <= dp_full[63:22];
            r_dz <= r_vz[NS];
            r_dn <= r_n[NS];
        end
    end

    // ---------------- checks, magnitude, angle rounding ----------------
    logic [DW:0]           r_rem [QB+1];
    logic [QB-1:0]         r_q   [QB+1];
    logic [QB-1:0]         r_lo  [QB+1];
    logic [DW-1:0]         r_dd  [QB+1];
    logic                  r_neg [QB+1];
    logic                  r_ovf [QB+1];
    logic                  r_deg [QB+1];
    logic signed [18:0]    r_th  [QB+1];
    logic                  r_qvld[QB+1];

    logic [NW-1:0]         mag;
    logic signed [VZW-1:0] zr;
    logic signed [VZW-15:0] th_w;
    logic signed [18:0]    th_c;

    assign mag  = r_dn[NW-1] ? NW'(-r_dn) : NW'(r_dn);
    assign zr   = r_dz + VZW'(8192);
    assign th_w = zr[VZW-1:14];

    always_comb begin
        priority if (th_w > $signed({2'b00, THETA_LIMIT})) begin
            th_c = $signed(THETA_LIMIT);
        end else if (th_w < -$signed({2'b00, THETA_LIMIT})) begin
            th_c = -$signed(THETA_LIMIT);
        end else begin
            th_c = th_w[18:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qvld[0] <= 1'b0;
        end else if (en) begin
            r_qvld[0] <= r_dvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0] <= (DW+1)'(mag[NW-1:26]);
            r_ovf[0] <= {{(DW-NW+26){1'b0}}, mag[NW-1:26]} >= r_d;
            r_q[0]   <= '0;
            r_lo[0]  <= {mag[25:0], 9'd0};
            r_dd[0]  <= r_d;
            r_neg[0] <= r_dn[NW-1];
            r_deg[0] <= r_d < DW'(D_MIN_Q24);
            r_th[0]  <= th_c;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [DW:0] t;
        logic        ge;
        assign t  = {r_rem[k][DW-1:0], r_lo[k][QB-1]};
        assign ge = t >= {1'b0, r_dd[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qvld[k+1] <= 1'b0;
            end else if (en) begin
                r_qvld[k+1] <= r_qvld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[k+1] <= ge ? t - {1'b0, r_dd[k]} : t;
                r_q[k+1]   <= {r_q[k][QB-2:0], ge};
                r_lo[k+1]  <= {r_lo[k][QB-2:0], 1'b0};
                r_dd[k+1]  <= r_dd[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
                r_deg[k+1] <= r_deg[k];
                r_th[k+1]  <= r_th[k];
            end
        end
    end

    // ---------------- rounding, saturation, output register ----------------
    logic [QB:0]   q_inc;
    logic [QB-1:0] res;
    logic [27:0]   lim;
    logic [27:0]   res_sat;
    logic [26:0]   rho_o;

    logic [26:0]   r_rho_pix;
    logic [18:0]   r_theta_pix;
    logic          r_degen;

    assign q_inc = {1'b0, r_q[QB]} + (QB+1)'(1);
    assign res   = q_inc[QB:1];
    assign lim   = r_neg[QB] ? RHO_NEG_LIMIT : {1'b0, RHO_POS_LIMIT};

    always_comb begin
        priority if (r_ovf[QB] || res > QB'(lim)) begin
            res_sat = lim;
        end else begin
            res_sat = res[27:0];
        end
        rho_o = r_neg[QB] ? 27'(-res_sat) : res_sat[26:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_qvld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_deg[QB]) begin
                r_rho_pix   <= '0;
                r_theta_pix <= '0;
                r_degen     <= 1'b1;
            end else begin
                r_rho_pix   <= rho_o;
                r_theta_pix <= r_th[QB];
                r_degen     <= 1'b0;
            end
        end
    end

    assign m_axis_tdata = {2'b00, r_theta_pix, r_rho_pix};
    assign m_axis_tuser = r_degen;

endmodule
